[src/fusp_pkg.sv]
// Shared types, codes and constants of the firmware update stream parser.
package fusp_pkg;

  localparam int unsigned START_BYTES = 4;
  localparam int unsigned MAX_BLOCK   = 256;
  localparam int unsigned RES_DEPTH   = 3;

  typedef enum logic [1:0] {
    STG_START,
    STG_META,
    STG_CHUNK,
    STG_END
  } stage_t;

  localparam logic [1:0] RS_INC  = 2'd0;
  localparam logic [1:0] RS_DONE = 2'd1;
  localparam logic [1:0] RS_BAD  = 2'd2;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_BLOCK = 3'd1;
  localparam logic [2:0] ACT_ERASE = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_FLUSH = 3'd4;
  localparam logic [2:0] ACT_APPLY = 3'd5;

  localparam logic [2:0] CFG_START_MAGIC = 3'd0;
  localparam logic [2:0] CFG_END_MAGIC   = 3'd1;
  localparam logic [2:0] CFG_VERSION     = 3'd2;
  localparam logic [2:0] CFG_TARGET      = 3'd3;
  localparam logic [2:0] CFG_SECTOR      = 3'd4;
  localparam logic [2:0] CFG_NATIVE      = 3'd5;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  action;
    logic [15:0] sector_index;
    logic [19:0] sector_offset;
    logic [7:0]  write_byte;
    logic [8:0]  block_size;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EVAL,
    CS_SRCH,
    CS_SWAIT,
    CS_CHK,
    CS_CWAIT,
    CS_COMMIT,
    CS_EMIT
  } cstate_t;

  typedef struct packed {
    logic load;
    logic init_pick;
    logic init_chk;
    logic div_start;
    logic srch_step;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_pick;
    logic need_check;
    logic cand_over;
    logic div_done;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

[src/fusp_rdiv.sv]
// Bit-serial restoring remainder unit: sector size modulo a block candidate.
module fusp_rdiv import fusp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [20:0] dividend,
  input  logic [8:0]  divisor,
  output logic        done,
  output logic        rem_zero
);

  logic [20:0] sh;
  logic [8:0]  rem;
  logic [8:0]  dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [9:0]  trial;
  logic        fits;

  assign trial = {rem, sh[20]};
  assign fits  = trial >= {1'b0, dvs};
  assign rem_zero = rem == 9'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd21;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= 9'd0;
      dvs <= divisor;
    end else if (busy) begin
      sh  <= {sh[19:0], 1'b0};
      rem <= fits ? 9'(trial - {1'b0, dvs}) : trial[8:0];
    end
  end

endmodule

[src/fusp_ctrl.sv]
// Sequencer: accept a word, run the block search or fit check, commit, emit results.
module fusp_ctrl import fusp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  cstate_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE:   if (in_valid) state_next = CS_EVAL;
      CS_EVAL: begin
        if (sts.need_pick) state_next = CS_SRCH;
        else if (sts.need_check) state_next = CS_CHK;
        else state_next = CS_EMIT;
      end
      CS_SRCH:   state_next = sts.cand_over ? CS_COMMIT : CS_SWAIT;
      CS_SWAIT:  if (sts.div_done) state_next = CS_SRCH;
      CS_CHK:    state_next = CS_CWAIT;
      CS_CWAIT:  if (sts.div_done) state_next = CS_COMMIT;
      CS_COMMIT: state_next = CS_EMIT;
      CS_EMIT:   if (sts.out_free && sts.emit_last) state_next = CS_IDLE;
      default:   state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      CS_EVAL: begin
        if (sts.need_pick) cmd.init_pick = 1'b1;
        else if (sts.need_check) cmd.init_chk = 1'b1;
        else cmd.commit = 1'b1;
      end
      CS_SRCH:   cmd.div_start = !sts.cand_over;
      CS_SWAIT:  cmd.srch_step = sts.div_done;
      CS_CHK:    cmd.div_start = 1'b1;
      CS_CWAIT:  cmd.srch_step = sts.div_done;
      CS_COMMIT: cmd.commit = 1'b1;
      CS_EMIT:   cmd.emit = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

[src/fusp_dpath.sv]
// Datapath: config registers, session state, step evaluation, result list and output register.
module fusp_dpath import fusp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [7:0]  byte_in,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);

  // configuration
  logic [63:0] start_magic;
  logic [31:0] end_magic, expected_version, expected_target;
  logic [20:0] sector_bytes;
  logic [8:0]  native_block;

  // session state
  stage_t      stage;
  logic [3:0]  start_matched, stage_count;
  logic [15:0] sector_now;
  logic [20:0] sector_fill;
  logic [31:0] payload_count, payload_size, got_target, got_version;
  logic [8:0]  chosen_block;
  logic        failed_flag;
  logic        dirty;

  stage_t      stage_next;
  logic [3:0]  start_matched_next, stage_count_next;
  logic [15:0] sector_now_next;
  logic [20:0] sector_fill_next;
  logic [31:0] payload_count_next, payload_size_next, got_target_next, got_version_next;
  logic [8:0]  chosen_block_next;
  logic        failed_flag_next, dirty_next;

  logic [7:0]  b;
  logic [9:0]  cand;
  logic [8:0]  best;
  logic [9:0]  cap;
  logic        div_done, rem_zero;

  res_t        res_list [RES_DEPTH];
  logic [1:0]  res_li;
  logic [1:0]  emit_idx;

  // step evaluation
  res_t        rl [RES_DEPTH];
  logic [1:0]  rn, li;
  logic [1:0]  st;
  logic        clr;
  stage_t      clr_stage;
  logic [3:0]  clr_sm;

  logic [7:0]  m_want, e_want;
  logic        m_hit, m_done;
  logic [3:0]  m_cnt1, m_next, retry_sm;
  logic        restart, nb_ok, pick_pre, pick_ok, chk_ok;
  logic [20:0] fill1;
  logic [31:0] pc1;
  logic [3:0]  sc1;

  assign m_want  = start_magic[{start_matched[2:0], 3'b000} +: 8];
  assign m_hit   = b == m_want;
  assign m_cnt1  = start_matched + 4'd1;
  assign m_done  = m_hit && (m_cnt1 >= 4'(START_BYTES));
  assign m_next  = (!m_hit || m_done) ? 4'd0 : m_cnt1;
  assign retry_sm = (b != start_magic[7:0]) ? 4'd0 :
                    ((4'd1 >= 4'(START_BYTES)) ? 4'd0 : 4'd1);
  assign e_want  = end_magic[{stage_count[1:0], 3'b000} +: 8];
  assign restart = (stage != STG_START) && m_done;

  assign nb_ok    = (native_block != 9'd0) && ({1'b0, native_block} <= 10'(MAX_BLOCK));
  assign pick_pre = nb_ok && (sector_bytes != 21'd0);
  assign pick_ok  = pick_pre && (best != 9'd0);
  assign chk_ok   = !dirty || (best != 9'd0);
  assign cap      = (sector_bytes >= 21'(MAX_BLOCK)) ? 10'(MAX_BLOCK) : sector_bytes[9:0];

  assign fill1 = sector_fill + 21'd1;
  assign pc1   = payload_count + 32'd1;

  assign sts.need_pick  = !failed_flag && !restart && (stage == STG_META) &&
                          (stage_count == 4'd11) && (got_version == expected_version) &&
                          (got_target == expected_target) && pick_pre;
  assign sts.need_check = !failed_flag && !restart && (stage == STG_CHUNK) &&
                          (sector_bytes != 21'd0) && dirty;
  assign sts.cand_over  = cand > cap;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.emit_last  = emit_idx == res_li;

  fusp_rdiv u_rdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sector_bytes),
    .divisor  (cand[8:0]),
    .done     (div_done),
    .rem_zero (rem_zero)
  );

  always_comb begin
    stage_next         = stage;
    start_matched_next = start_matched;
    stage_count_next   = stage_count;
    sector_now_next    = sector_now;
    sector_fill_next   = sector_fill;
    payload_count_next = payload_count;
    payload_size_next  = payload_size;
    got_target_next    = got_target;
    got_version_next   = got_version;
    chosen_block_next  = chosen_block;
    failed_flag_next   = failed_flag;
    dirty_next         = dirty;
    st        = RS_INC;
    rn        = 2'd0;
    clr       = 1'b0;
    clr_stage = STG_START;
    clr_sm    = 4'd0;
    sc1       = stage_count + 4'd1;
    for (int i = 0; i < RES_DEPTH; i++) rl[i] = '0;

    if (failed_flag) begin
      if (m_done) begin
        clr = 1'b1;
        clr_stage = STG_META;
        failed_flag_next = 1'b0;
      end else begin
        start_matched_next = m_next;
        st = RS_BAD;
      end
    end else if (restart) begin
      clr = 1'b1;
      clr_stage = STG_META;
    end else begin
      start_matched_next = m_next;
      unique case (stage)
        STG_START: begin
          if (m_done) begin
            stage_next = STG_META;
            stage_count_next = 4'd0;
          end else if (!m_hit) begin
            clr = 1'b1;
            clr_sm = retry_sm;
            st = RS_BAD;
          end
        end
        STG_META: begin
          unique case (stage_count[3:2])
            2'd0: got_version_next[{stage_count[1:0], 3'b000} +: 8] = b;
            2'd1: got_target_next[{stage_count[1:0], 3'b000} +: 8] = b;
            2'd2: payload_size_next[{stage_count[1:0], 3'b000} +: 8] = b;
            default: ;
          endcase
          if (sc1 != 4'd12) begin
            stage_count_next = sc1;
          end else if (got_version_next != expected_version ||
                       got_target_next != expected_target) begin
            clr = 1'b1;
            clr_sm = retry_sm;
            st = RS_BAD;
          end else if (!pick_ok) begin
            failed_flag_next = 1'b1;
            clr = 1'b1;
            st = RS_BAD;
          end else begin
            rl[0].action     = ACT_BLOCK;
            rl[0].block_size = best;
            rn = 2'd1;
            chosen_block_next = best;
            dirty_next = 1'b0;
            stage_next = STG_CHUNK;
            stage_count_next = 4'd0;
          end
        end
        STG_CHUNK: begin
          if (sector_bytes == 21'd0 || !chk_ok || sector_fill >= sector_bytes) begin
            failed_flag_next = 1'b1;
            clr = 1'b1;
            st = RS_BAD;
          end else begin
            dirty_next = 1'b0;
            if (sector_fill == 21'd0) begin
              rl[0].action       = ACT_ERASE;
              rl[0].sector_index = sector_now;
              rn = 2'd1;
            end
            rl[rn].action        = ACT_WRITE;
            rl[rn].sector_index  = sector_now;
            rl[rn].sector_offset = sector_fill[19:0];
            rl[rn].write_byte    = b;
            rn = rn + 2'd1;
            payload_count_next = pc1;
            sector_fill_next   = fill1;
            if (pc1 == payload_size || fill1 == sector_bytes) begin
              rl[rn].action       = ACT_FLUSH;
              rl[rn].sector_index = sector_now;
              rn = rn + 2'd1;
              sector_fill_next = 21'd0;
            end
            if (pc1 == payload_size) begin
              stage_next = STG_END;
              stage_count_next = 4'd0;
            end else if (fill1 == sector_bytes) begin
              sector_now_next = sector_now + 16'd1;
            end
          end
        end
        STG_END: begin
          if (b != e_want) begin
            clr = 1'b1;
            clr_sm = retry_sm;
            st = RS_BAD;
          end else if (sc1 >= 4'd4) begin
            rl[0].action = ACT_APPLY;
            rn = 2'd1;
            clr = 1'b1;
            st = RS_DONE;
          end else begin
            stage_count_next = sc1;
          end
        end
        default: ;
      endcase
    end

    // clear the session, keep or drop the failure mark as set above
    if (clr) begin
      stage_next         = clr_stage;
      start_matched_next = clr_sm;
      stage_count_next   = 4'd0;
      sector_now_next    = 16'd0;
      sector_fill_next   = 21'd0;
      payload_count_next = 32'd0;
      payload_size_next  = 32'd0;
      got_target_next    = 32'd0;
      got_version_next   = 32'd0;
      chosen_block_next  = 9'd0;
    end

    if (rn == 2'd0) begin
      rl[0].action = ACT_NONE;
      rn = 2'd1;
    end
    li = rn - 2'd1;
    rl[li].status = st;
    rl[li].last   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_magic      <= 64'd0;
      end_magic        <= 32'd0;
      expected_version <= 32'd0;
      expected_target  <= 32'd0;
      sector_bytes     <= 21'd4096;
      native_block     <= 9'd4;
      stage            <= STG_START;
      start_matched    <= 4'd0;
      stage_count      <= 4'd0;
      sector_now       <= 16'd0;
      sector_fill      <= 21'd0;
      payload_count    <= 32'd0;
      payload_size     <= 32'd0;
      got_target       <= 32'd0;
      got_version      <= 32'd0;
      chosen_block     <= 9'd0;
      failed_flag      <= 1'b0;
      dirty            <= 1'b0;
      out_valid        <= 1'b0;
      emit_idx         <= 2'd0;
      res_li           <= 2'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_MAGIC: start_magic      <= cfg_data;
          CFG_END_MAGIC:   end_magic        <= cfg_data[31:0];
          CFG_VERSION:     expected_version <= cfg_data[31:0];
          CFG_TARGET:      expected_target  <= cfg_data[31:0];
          CFG_SECTOR:      sector_bytes     <= cfg_data[20:0];
          CFG_NATIVE:      native_block     <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        stage         <= stage_next;
        start_matched <= start_matched_next;
        stage_count   <= stage_count_next;
        sector_now    <= sector_now_next;
        sector_fill   <= sector_fill_next;
        payload_count <= payload_count_next;
        payload_size  <= payload_size_next;
        got_target    <= got_target_next;
        got_version   <= got_version_next;
        chosen_block  <= chosen_block_next;
        failed_flag   <= failed_flag_next;
        dirty         <= dirty_next;
        res_li        <= li;
        emit_idx      <= 2'd0;
      end else if (cmd.emit) begin
        emit_idx <= emit_idx + 2'd1;
      end
      // a new sector size must be rechecked against the chosen block
      if (cfg_we && cfg_index == CFG_SECTOR) dirty <= 1'b1;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) b <= byte_in;
    if (cmd.init_pick) begin
      cand <= {1'b0, native_block};
      best <= 9'd0;
    end else if (cmd.init_chk) begin
      cand <= {1'b0, chosen_block};
      best <= 9'd0;
    end else if (cmd.srch_step) begin
      if (rem_zero) best <= cand[8:0];
      cand <= cand + {1'b0, native_block};
    end
    if (cmd.commit) begin
      for (int i = 0; i < RES_DEPTH; i++) res_list[i] <= rl[i];
    end
    if (cmd.emit) out_res <= res_list[emit_idx];
  end

endmodule

[src/firmware_update_stream_parser.sv]
// Top level of the firmware update stream parser: ports, sequencer, datapath, checks.
//
//  channel   dir  handshake                       contents
//  s_axis    in   s_axis_tvalid / s_axis_tready   one stream byte per word
//  m_axis    out  m_axis_tvalid / m_axis_tready   one flash request per word, tlast ends a byte
//  cfg       in   cfg_we                          register index and data, write only
//
// One byte at a time: accept, evaluate, then emit the byte's result words in order.
// Completing the metadata runs the block-size search on the shared bit-serial
// remainder unit, one remainder per multiple of native_block up to min(sector, 256).
// The first payload byte after a sector_bytes write pays one fit check.
// rst is synchronous; it restores the register defaults and an empty session.
// A stalled output holds the sequencer in its emit step; s_axis_tready stays low until
// the last result word of the byte is in the output register.
module firmware_update_stream_parser import fusp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [4:2] action, [20:5] sector_index, [40:21] sector_offset,
  // [48:41] write_byte, [57:49] block_size, [63:58] zero
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  res_t out_res;

  fusp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fusp_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_in   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // pack the result word, first field lowest
  assign m_axis_tdata = {6'd0, out_res.block_size, out_res.write_byte, out_res.sector_offset,
                         out_res.sector_index, out_res.action, out_res.status};
  assign m_axis_tlast = out_res.last;

  // one byte in flight: no second accept right behind the first
  a_one_byte: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a byte is still in work");

  // only the last word of a byte carries a status
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[1:0] == RS_INC))
    else $error("status on a word that is not the last of its byte");

  // a status word never carries the unused code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == RS_INC || m_axis_tdata[1:0] == RS_DONE ||
                       m_axis_tdata[1:0] == RS_BAD))
    else $error("unknown status code");

  // an output word always names a real request code
  a_action_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[4:2] <= ACT_APPLY))
    else $error("unknown action code");

endmodule

[tb/fusp_checker.sv]
// Checker for the firmware update stream parser: predicts request words and compares them.
module fusp_checker import fusp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          words_pending
);

  // register copies
  logic [63:0] start_magic_r;
  logic [31:0] end_magic_r, version_r, target_r;
  logic [20:0] sector_r;
  logic [8:0]  native_r;

  // session state
  stage_t      stg;
  logic [3:0]  start_hits, stage_cnt;
  logic [15:0] sector_cur;
  logic [20:0] fill;
  logic [31:0] pay_cnt, pay_size, got_tgt, got_ver;
  logic [8:0]  block_sel;
  logic        failed;

  res_t byte_reqs[$];
  res_t expected_words[$];

  assign words_pending = expected_words.size();

  function automatic void push_req(logic [2:0] act, logic [15:0] idx, logic [19:0] off,
                                   logic [7:0] wb, logic [8:0] blk);
    res_t r;
    r = '{status: RS_INC, action: act, sector_index: idx, sector_offset: off,
          write_byte: wb, block_size: blk, last: 1'b0};
    if (byte_reqs.size() < 4) byte_reqs.push_back(r);
  endfunction

  function automatic void clear_session(logic clr_fail);
    stg = STG_START;
    start_hits = '0; stage_cnt = '0; sector_cur = '0; fill = '0;
    pay_cnt = '0; pay_size = '0; got_tgt = '0; got_ver = '0; block_sel = '0;
    if (clr_fail) failed = 1'b0;
  endfunction

  function automatic logic [1:0] enter_failed();
    failed = 1'b1;
    clear_session(1'b0);
    return RS_BAD;
  endfunction

  function automatic logic [1:0] match_start(logic [7:0] b);
    logic [7:0] want;
    want = start_magic_r[8*start_hits[2:0] +: 8];
    if (want != b) begin
      start_hits = '0;
      return RS_BAD;
    end
    start_hits = start_hits + 4'd1;
    if (start_hits >= START_BYTES) begin
      start_hits = '0;
      return RS_DONE;
    end
    return RS_INC;
  endfunction

  // largest multiple of the native granule that divides the sector, capped at MAX_BLOCK
  function automatic logic search_block();
    int unsigned nb, sb, w;
    nb = native_r;
    sb = sector_r;
    if (nb == 0 || nb > MAX_BLOCK) return 1'b0;
    if (sb == 0 || (sb % nb) != 0) return 1'b0;
    w = (sb < MAX_BLOCK) ? sb : MAX_BLOCK;
    while (w > nb && ((w % nb) != 0 || (sb % w) != 0)) w--;
    if (w == 0 || (w % nb) != 0 || (sb % w) != 0) return 1'b0;
    block_sel = w[8:0];
    return 1'b1;
  endfunction

  function automatic logic [1:0] take_meta(logic [7:0] b);
    if (stage_cnt < 4) got_ver[8*stage_cnt[1:0] +: 8] = got_ver[8*stage_cnt[1:0] +: 8] | b;
    else if (stage_cnt < 8) got_tgt[8*stage_cnt[1:0] +: 8] = got_tgt[8*stage_cnt[1:0] +: 8] | b;
    else if (stage_cnt < 12) pay_size[8*stage_cnt[1:0] +: 8] = pay_size[8*stage_cnt[1:0] +: 8] | b;
    stage_cnt = stage_cnt + 4'd1;
    if (stage_cnt != 4'd12) return RS_INC;
    if (got_ver != version_r) return RS_BAD;
    if (got_tgt != target_r) return RS_BAD;
    if (!search_block()) return enter_failed();
    push_req(ACT_BLOCK, '0, '0, '0, block_sel);
    return RS_DONE;
  endfunction

  function automatic logic [1:0] take_payload(logic [7:0] b);
    if (sector_r == 0 || block_sel == 0) return enter_failed();
    if ((sector_r % block_sel) != 0) return enter_failed();
    if (fill >= sector_r) return enter_failed();
    if (fill == 0) push_req(ACT_ERASE, sector_cur, '0, '0, '0);
    push_req(ACT_WRITE, sector_cur, fill[19:0], b, '0);
    fill = fill + 21'd1;
    pay_cnt = pay_cnt + 32'd1;
    if (pay_cnt == pay_size) begin
      push_req(ACT_FLUSH, sector_cur, '0, '0, '0);
      fill = '0;
      stage_cnt = '0;
      return RS_DONE;
    end
    if (fill == sector_r) begin
      push_req(ACT_FLUSH, sector_cur, '0, '0, '0);
      fill = '0;
      sector_cur = sector_cur + 16'd1;
    end
    return RS_INC;
  endfunction

  function automatic logic [1:0] take_end(logic [7:0] b);
    if (end_magic_r[8*stage_cnt[1:0] +: 8] != b) begin
      stage_cnt = '0;
      return RS_BAD;
    end
    stage_cnt = stage_cnt + 4'd1;
    if (stage_cnt >= 4) begin
      stage_cnt = '0;
      return RS_DONE;
    end
    return RS_INC;
  endfunction

  function automatic logic [1:0] run_stage(logic [7:0] b);
    case (stg)
      STG_START: return match_start(b);
      STG_META:  return take_meta(b);
      STG_CHUNK: return take_payload(b);
      default:   return take_end(b);
    endcase
  endfunction

  function automatic logic [1:0] next_stage();
    if (stg == STG_END) begin
      if (!failed) push_req(ACT_APPLY, '0, '0, '0, '0);
      clear_session(1'b1);
      return RS_DONE;
    end
    stage_cnt = '0;
    stg = stage_t'(stg + 2'd1);
    return RS_INC;
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    logic [1:0] st, r;
    logic       wf;
    res_t       tail;
    byte_reqs.delete();
    if (failed) begin
      if (match_start(b) == RS_DONE) begin
        clear_session(1'b1);
        stg = STG_META;
        st = RS_INC;
      end else begin
        st = RS_BAD;
      end
    end else if (stg != STG_START && match_start(b) == RS_DONE) begin
      // restart of the session from any later stage
      clear_session(1'b1);
      st = next_stage();
    end else begin
      r = run_stage(b);
      if (r == RS_DONE) begin
        st = next_stage();
      end else if (r == RS_BAD) begin
        // drop the session and, unless it is now failed, retry the byte as the first start byte
        wf = failed;
        clear_session(!wf);
        if (!wf && run_stage(b) == RS_BAD) clear_session(1'b1);
        st = RS_BAD;
      end else begin
        st = RS_INC;
      end
    end
    if (byte_reqs.size() == 0) push_req(ACT_NONE, '0, '0, '0, '0);
    tail = byte_reqs.pop_back();
    tail.status = st;
    tail.last = 1'b1;
    byte_reqs.push_back(tail);
    foreach (byte_reqs[i]) expected_words.push_back(byte_reqs[i]);
  endfunction

  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      start_magic_r <= '0;
      end_magic_r <= '0;
      version_r <= '0;
      target_r <= '0;
      sector_r <= 21'd4096;
      native_r <= 9'd4;
      clear_session(1'b1);
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_MAGIC: start_magic_r <= cfg_data;
          CFG_END_MAGIC:   end_magic_r <= cfg_data[31:0];
          CFG_VERSION:     version_r <= cfg_data[31:0];
          CFG_TARGET:      target_r <= cfg_data[31:0];
          CFG_SECTOR:      sector_r <= cfg_data[20:0];
          CFG_NATIVE:      native_r <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{status: m_axis_tdata[1:0], action: m_axis_tdata[4:2],
                sector_index: m_axis_tdata[20:5], sector_offset: m_axis_tdata[40:21],
                write_byte: m_axis_tdata[48:41], block_size: m_axis_tdata[57:49],
                last: m_axis_tlast};
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected request word %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status || got.action !== want.action ||
              got.sector_index !== want.sector_index ||
              got.sector_offset !== want.sector_offset ||
              got.write_byte !== want.write_byte ||
              got.block_size !== want.block_size || got.last !== want.last) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[tb/tb_top.sv]
// Stimulus and verdict for the firmware update stream parser testbench.
module tb_top import fusp_pkg::*;;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_START_MAGIC;
  logic [63:0] cfg_data = '0;

  int fail_count;
  int words_pending;

  // local copies of the markers and ids, used to build streams
  logic [63:0] start_key;
  logic [31:0] end_key, version_key, target_key;
  logic [20:0] sector_size;
  bit          no_idle;
  int          random_bytes;

  always #1 clk = ~clk;

  firmware_update_stream_parser i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fusp_checker i_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  // Receiver: draw a stall per word, then hold tready until a word is taken.
  // Sample tvalid at the falling edge so the handshake is known before the rising one.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk);
      while (!m_axis_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  // Send one stream byte: optional gap, then hold tvalid until the word is taken.
  // tvalid is lowered only when a gap follows, so it never gets two updates in a step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // Drain: drop tvalid, wait for every expected word, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Write all six registers back to back; only called with the block idle.
  task automatic load_regs(input logic [63:0] sm, input logic [31:0] em,
                           input logic [31:0] ver, input logic [31:0] tgt,
                           input logic [20:0] sec, input logic [8:0] nat);
    start_key = sm; end_key = em; version_key = ver; target_key = tgt; sector_size = sec;
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_MAGIC; cfg_data <= sm;  @(posedge clk);
    cfg_index <= CFG_END_MAGIC;   cfg_data <= {32'd0, em};  @(posedge clk);
    cfg_index <= CFG_VERSION;     cfg_data <= {32'd0, ver}; @(posedge clk);
    cfg_index <= CFG_TARGET;      cfg_data <= {32'd0, tgt}; @(posedge clk);
    cfg_index <= CFG_SECTOR;      cfg_data <= {43'd0, sec}; @(posedge clk);
    cfg_index <= CFG_NATIVE;      cfg_data <= {55'd0, nat}; @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_start();
    for (int i = 0; i < START_BYTES; i++) send_byte(start_key[8*i +: 8]);
  endtask

  task automatic send_word32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  // One session. Flip a version, target or end bit to break it on purpose;
  // cut_at >= 0 restarts with a fresh start marker after that many payload bytes.
  task automatic send_session(input logic [31:0] size, input int npay,
                              input bit bad_ver, input bit bad_tgt, input bit bad_end,
                              input int cut_at);
    send_start();
    send_word32(version_key ^ {31'd0, bad_ver});
    send_word32(target_key ^ {31'd0, bad_tgt});
    send_word32(size);
    for (int i = 0; i < npay; i++) begin
      if (i == cut_at) begin
        send_start();
        return;
      end
      send_byte($urandom_range(0, 255));
    end
    send_word32(end_key ^ {31'd0, bad_end});
  endtask

  // Random sessions: mostly well-formed with random sizes and content, plus noise,
  // broken headers, bad end markers and restarts in the middle of a payload.
  task automatic random_phase(input int quota);
    int n, kind, size;
    n = 0;
    while (n < quota) begin
      no_idle = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      size = $urandom_range(1, 24);
      case (kind)
        0: begin
          for (int i = 0; i < 3; i++) send_byte($urandom_range(0, 255));
          n += 3;
        end
        1: begin
          send_session(size, 0, $urandom_range(0, 1), 1'b1, 1'b0, -1);
          n += 12 + START_BYTES;
        end
        2: begin
          send_session(size, size, 1'b0, 1'b0, 1'b1, -1);
          n += 16 + START_BYTES + size;
        end
        3: begin
          send_session(size, size, 1'b0, 1'b0, 1'b0, size / 2);
          n += 12 + 2 * START_BYTES + size / 2;
        end
        default: begin
          send_session(size, size, 1'b0, 1'b0, 1'b0, -1);
          n += 16 + START_BYTES + size;
        end
      endcase
    end
    random_bytes += n;
    no_idle = 1'b0;
  endtask

  initial begin
    no_idle = 1'b0;
    random_bytes = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset registers, an all-zero start marker and header
    start_key = '0; end_key = '0; version_key = '0; target_key = '0; sector_size = 21'd4096;
    send_session(32'd2, 2, 1'b0, 1'b0, 1'b0, -1);
    drain();

    // Small sector of 8 with granule 4: erase, write, flush across sector ends, apply
    load_regs(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
              21'd8, 9'd4);
    send_session(32'd9, 9, 1'b0, 1'b0, 1'b0, -1);
    send_session(32'd1, 0, 1'b1, 1'b0, 1'b0, -1);   // wrong version
    send_session(32'd1, 0, 1'b0, 1'b1, 1'b0, -1);   // wrong target
    drain();

    // Granule above the maximum: metadata fails, bytes stay invalid until a start marker
    load_regs($urandom, $urandom, $urandom, $urandom, 21'd1048576, 9'd511);
    send_session(32'd1, 0, 1'b0, 1'b0, 1'b0, -1);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();

    // Zero granule and zero sector both fail; zero payload size wraps, restart cuts it
    load_regs($urandom, $urandom, $urandom, $urandom, 21'd16, 9'd0);
    send_session(32'd1, 0, 1'b0, 1'b0, 1'b0, -1);
    drain();
    load_regs({$urandom, $urandom}, $urandom, $urandom, $urandom, 21'd0, 9'd256);
    send_session(32'd1, 0, 1'b0, 1'b0, 1'b0, -1);
    drain();
    load_regs({$urandom, $urandom}, $urandom, $urandom, $urandom, 21'd7, 9'd1);
    send_session(32'd0, 6, 1'b0, 1'b0, 1'b0, 3);
    drain();

    // Random phases over several geometries, extremes among them.
    // Hold the sender until every word is back before each register change.
    load_regs({$urandom, $urandom}, $urandom, $urandom, $urandom, 21'd12, 9'd3);
    random_phase(40);
    drain();
    load_regs({$urandom, $urandom}, $urandom, $urandom, $urandom, 21'd16, 9'd5);
    random_phase(20);
    drain();
    load_regs({$urandom, $urandom}, $urandom, $urandom, $urandom, 21'd1048576, 9'd256);
    random_phase(40);
    drain();
    load_regs({$urandom, $urandom}, $urandom, $urandom, $urandom, 21'd4, 9'd1);
    random_phase(60);
    drain();

    if (fail_count == 0 && words_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
src/fusp_pkg.sv
src/fusp_rdiv.sv
src/fusp_ctrl.sv
src/fusp_dpath.sv
src/firmware_update_stream_parser.sv
tb/fusp_checker.sv
tb/tb_top.sv
